>>> rtl/core/s16n_pkg.sv
// ============================================================================
// s16n_pkg: shared types and helpers for the 16-key sorter
// Holds the key vector type, the rank mapping and the item queue depth.
// ============================================================================
package s16n_pkg;

    localparam int unsigned KEY_W      = 32;
    localparam int unsigned LANES      = 4;
    localparam int unsigned BLOCK_KEYS = 16;
    localparam int unsigned QUEUE_DEPTH = 4;

    typedef logic [KEY_W-1:0] key_t;
    typedef key_t [LANES-1:0] vec_t;

    // queue entry: one four-key item plus its end-of-block mark
    typedef struct packed {
        vec_t keys;
        logic last;
    } item_t;

    // Map a float pattern to an unsigned rank that orders as the real value.
    function automatic key_t order_rank(input key_t bits);
        key_t r;
        if (bits[KEY_W-1]) begin
            r = ~bits;
        end else begin
            r = bits | {1'b1, {(KEY_W-1){1'b0}}};
        end
        return r;
    endfunction

    // true when key a orders above key b
    function automatic logic key_gt(input key_t a, input key_t b);
        return order_rank(a) > order_rank(b);
    endfunction

endpackage

>>> rtl/core/s16n_front.sv
// ============================================================================
// s16n_front: input side of the sorter
// Accepts four-key items, counts them within a block and pushes each one,
// marked when it closes a block, into the item queue.
// ============================================================================
module s16n_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  s16n_pkg::vec_t      in_keys,
    output logic                push,
    output s16n_pkg::item_t     push_item,
    input  logic                q_full
);

    logic [1:0] load_count_reg;
    logic [1:0] load_count_next;

    assign in_ready  = !q_full;
    assign push      = in_valid && !q_full;
    assign push_item = '{keys: in_keys, last: (load_count_reg == 2'd3)};

    // advance the item count on every accepted request
    always_comb begin
        load_count_next = load_count_reg;
        if (push) begin
            load_count_next = load_count_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_count_reg <= 2'd0;
        end else begin
            load_count_reg <= load_count_next;
        end
    end

endmodule

>>> rtl/core/s16n_queue.sv
// ============================================================================
// s16n_queue: short item queue between front and back
// Small register FIFO that lets intake and sorting stall independently.
// ============================================================================
module s16n_queue #(
    parameter int unsigned DEPTH = s16n_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  s16n_pkg::item_t  push_item,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output s16n_pkg::item_t  head_item
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    s16n_pkg::item_t mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [AW:0]     count_reg,  count_next;

    assign full      = (count_reg == (AW+1)'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_item = mem_reg[rd_ptr_reg];

    // advance pointers and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + (AW+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (AW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // store entries
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> rtl/core/s16n_back.sv
// ============================================================================
// s16n_back: sorting side of the sorter
// Collects four items from the queue, runs an odd-even transposition sort
// over 16 keys (one compare-exchange layer a cycle, 16 layers), then emits
// the sorted block as four results.
// ============================================================================
module s16n_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_not_empty,
    input  s16n_pkg::item_t  q_head,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output s16n_pkg::vec_t   out_keys,
    output logic             out_last
);

    localparam int unsigned N = s16n_pkg::BLOCK_KEYS;

    typedef enum logic [2:0] {
        ST_LOAD = 3'b001,
        ST_SORT = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    s16n_pkg::key_t     buf_reg  [N];
    s16n_pkg::key_t     buf_next [N];
    logic [1:0]         slot_reg, slot_next;
    logic [3:0]         layer_reg, layer_next;

    assign q_pop     = (state_reg == ST_LOAD) && q_not_empty;
    assign out_valid = (state_reg == ST_EMIT);
    assign out_last  = (slot_reg == 2'd3);

    // select current output row
    always_comb begin
        for (int l = 0; l < s16n_pkg::LANES; l++) begin
            out_keys[l] = buf_reg[{slot_reg, 2'(l)}];
        end
    end

    // next state, counters and key buffer
    always_comb begin
        state_next = state_reg;
        slot_next  = slot_reg;
        layer_next = layer_reg;
        for (int i = 0; i < N; i++) begin
            buf_next[i] = buf_reg[i];
        end
        unique case (state_reg)
            ST_LOAD: begin
                if (q_pop) begin
                    for (int l = 0; l < s16n_pkg::LANES; l++) begin
                        buf_next[{slot_reg, 2'(l)}] = q_head.keys[l];
                    end
                    slot_next = slot_reg + 2'd1;
                    if (q_head.last) begin
                        slot_next  = 2'd0;
                        layer_next = 4'd0;
                        state_next = ST_SORT;
                    end
                end
            end
            ST_SORT: begin
                // one compare-exchange layer, even or odd pairs
                for (int p = 0; p < N - 1; p++) begin
                    if ((p % 2) == (layer_reg[0] ? 1 : 0)) begin
                        if (s16n_pkg::key_gt(buf_reg[p], buf_reg[p+1])) begin
                            buf_next[p]   = buf_reg[p+1];
                            buf_next[p+1] = buf_reg[p];
                        end
                    end
                end
                layer_next = layer_reg + 4'd1;
                if (layer_reg == 4'd15) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_ready) begin
                    slot_next = slot_reg + 2'd1;
                    if (slot_reg == 2'd3) begin
                        state_next = ST_LOAD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            slot_reg  <= 2'd0;
            layer_reg <= 4'd0;
        end else begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            layer_reg <= layer_next;
        end
    end

    // hold keys
    always_ff @(posedge aclk) begin
        for (int i = 0; i < N; i++) begin
            buf_reg[i] <= buf_next[i];
        end
    end

endmodule

>>> rtl/core/sort16_network_top.sv
// ============================================================================
// sort16_network_top: 16-key float sorter
// Sorts blocks of 16 single-precision keys delivered as four 4-key requests.
// ============================================================================
// channel | dir | tdata fields (low bit up)             | tlast
// s_axis  | in  | key_0, key_1, key_2, key_3             | -
// m_axis  | out | out_key_0 .. out_key_3                 | last_of_block
//
// A block is loaded from the queue, passed through the compare-exchange layer
// loop of the back end, and then emitted; the back end pops no new request
// until it has emitted its block. The 4-entry queue keeps intake running
// while a block sorts. Reset is synchronous, active low, and clears control
// state only. Either side may stall at any cycle.
module sort16_network_top #(
    parameter int unsigned QUEUE_DEPTH = s16n_pkg::QUEUE_DEPTH
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // key_0, key_1, key_2, key_3
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // out_key_0, out_key_1, out_key_2, out_key_3
    output logic         m_axis_tlast
);

    s16n_pkg::vec_t  in_keys;
    s16n_pkg::vec_t  out_keys;
    s16n_pkg::item_t push_item;
    s16n_pkg::item_t head_item;
    logic            push, q_full, pop, q_not_empty;

    // unpack lanes
    always_comb begin
        for (int l = 0; l < s16n_pkg::LANES; l++) begin
            in_keys[l] = s_axis_tdata[l*32 +: 32];
            m_axis_tdata[l*32 +: 32] = out_keys[l];
        end
    end

    s16n_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_keys   (in_keys),
        .push      (push),
        .push_item (push_item),
        .q_full    (q_full)
    );

    s16n_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head_item (head_item)
    );

    s16n_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (head_item),
        .q_pop       (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_keys    (out_keys),
        .out_last    (m_axis_tlast)
    );

endmodule
